[rtl/pknock_pkg.sv]
// ----------------------------------------------------------------------------
// Port knock gate package
// Widths, limits, register indexes and reset values shared by the gate files.
// ----------------------------------------------------------------------------
`default_nettype none

package pknock_pkg;

	localparam int unsigned MAX_KNOCKS = 10;
	localparam int unsigned TICK_W     = 32;
	localparam int unsigned PORT_W     = 16;
	localparam int unsigned IDX_W      = 4;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 64;

	typedef logic [PORT_W-1:0]     port_t;
	typedef logic [TICK_W-1:0]     tick_t;
	typedef logic [IDX_W-1:0]      knock_idx_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	localparam cfg_idx_t CFG_PROTECTED_PORT   = 3'd0;
	localparam cfg_idx_t CFG_TIMEOUT_TICKS    = 3'd1;
	localparam cfg_idx_t CFG_SEQUENCE_LENGTH  = 3'd2;
	localparam cfg_idx_t CFG_KNOCK_PORTS_LOW  = 3'd3;
	localparam cfg_idx_t CFG_KNOCK_PORTS_MID  = 3'd4;
	localparam cfg_idx_t CFG_KNOCK_PORTS_HIGH = 3'd5;

	localparam port_t             RST_PROTECTED_PORT   = 16'd22;
	localparam tick_t             RST_TIMEOUT_TICKS    = 32'd5000;
	localparam knock_idx_t        RST_SEQUENCE_LENGTH  = 4'd3;
	localparam logic [63:0]       RST_KNOCK_PORTS_LOW  = 64'h0000_115C_10E1_04D2;
	localparam logic [63:0]       RST_KNOCK_PORTS_MID  = 64'h0;
	localparam logic [31:0]       RST_KNOCK_PORTS_HIGH = 32'h0;

	localparam knock_idx_t LEN_MIN = 4'd1;
	localparam knock_idx_t LEN_MAX = knock_idx_t'(MAX_KNOCKS);

endpackage

`default_nettype wire

[rtl/pknock_in_if.sv]
// ----------------------------------------------------------------------------
// Port knock gate packet channel
// Valid/ready channel carrying one packet header summary per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface pknock_in_if;
	logic                  valid;
	logic                  ready;
	logic                  is_tcp;
	pknock_pkg::port_t     dest_port;
	pknock_pkg::tick_t     now_tick;

	modport source (output valid, output is_tcp, output dest_port, output now_tick,
		input ready);
	modport sink (input valid, input is_tcp, input dest_port, input now_tick,
		output ready);
endinterface

`default_nettype wire

[rtl/pknock_out_if.sv]
// ----------------------------------------------------------------------------
// Port knock gate verdict channel
// Valid/ready channel carrying the accept verdict and gate state per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface pknock_out_if;
	logic valid;
	logic ready;
	logic accept;
	logic gate_is_open;

	modport source (output valid, output accept, output gate_is_open, input ready);
	modport sink (input valid, input accept, input gate_is_open, output ready);
endinterface

`default_nettype wire

[rtl/pknock_cfg_if.sv]
// ----------------------------------------------------------------------------
// Port knock gate configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface pknock_cfg_if;
	logic                  valid;
	logic                  ready;
	pknock_pkg::cfg_idx_t  index;
	pknock_pkg::cfg_data_t data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/port_knock_gate.sv]
// ----------------------------------------------------------------------------
// Port knock gate
// Guards one TCP port behind a knock sequence of up to ten ports. Each packet
// request passes an input register and then a result register, which offers
// its verdict; one packet is taken every cycle while the verdict channel is
// not stalled. The gate state (open flag, knock index, last knock tick) is
// read and rewritten in the single cycle a packet leaves the input register,
// which holds the rate at one packet per cycle. Non-TCP packets are accepted;
// TCP packets to the protected port pass only while the gate is open; any
// other TCP packet first applies the timeout, then may advance the sequence.
// Configuration writes are always taken and are meant for idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

module port_knock_gate (
	input  wire              clk,
	input  wire              arst_n,
	pknock_in_if.sink        pkt,
	pknock_out_if.source     res,
	pknock_cfg_if.sink       cfg
);

	// configuration
	pknock_pkg::port_t      prot_port_q;
	pknock_pkg::tick_t      timeout_q;
	pknock_pkg::knock_idx_t seq_len_q;
	logic [63:0]            ports_low_q;
	logic [63:0]            ports_mid_q;
	logic [31:0]            ports_high_q;

	// gate state
	logic                   gate_open_q;
	pknock_pkg::knock_idx_t knock_idx_q;
	pknock_pkg::tick_t      last_tick_q;

	// input stage
	logic                   valid_s1;
	logic                   is_tcp_s1;
	pknock_pkg::port_t      dest_port_s1;
	pknock_pkg::tick_t      now_tick_s1;

	// result stage
	logic                   valid_s2;
	logic                   accept_s2;
	logic                   gate_is_open_s2;

	logic                   advance;
	logic                   hit_prot;
	logic                   do_knock;
	logic                   expired;
	pknock_pkg::knock_idx_t eff_len;
	pknock_pkg::knock_idx_t idx_base;
	pknock_pkg::knock_idx_t idx_inc;
	logic                   gate_base;
	pknock_pkg::tick_t      last_base;
	pknock_pkg::port_t      slot_port;
	logic                   match;
	pknock_pkg::knock_idx_t idx_next;
	logic                   gate_next;
	pknock_pkg::tick_t      last_next;
	logic                   accept_c;
	logic                   gate_is_open_c;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prot_port_q  <= pknock_pkg::RST_PROTECTED_PORT;
			timeout_q    <= pknock_pkg::RST_TIMEOUT_TICKS;
			seq_len_q    <= pknock_pkg::RST_SEQUENCE_LENGTH;
			ports_low_q  <= pknock_pkg::RST_KNOCK_PORTS_LOW;
			ports_mid_q  <= pknock_pkg::RST_KNOCK_PORTS_MID;
			ports_high_q <= pknock_pkg::RST_KNOCK_PORTS_HIGH;
		end else if (cfg.valid) begin
			case (cfg.index)
				pknock_pkg::CFG_PROTECTED_PORT:   prot_port_q  <= cfg.data[15:0];
				pknock_pkg::CFG_TIMEOUT_TICKS:    timeout_q    <= cfg.data[31:0];
				pknock_pkg::CFG_SEQUENCE_LENGTH:  seq_len_q    <= cfg.data[3:0];
				pknock_pkg::CFG_KNOCK_PORTS_LOW:  ports_low_q  <= cfg.data;
				pknock_pkg::CFG_KNOCK_PORTS_MID:  ports_mid_q  <= cfg.data;
				pknock_pkg::CFG_KNOCK_PORTS_HIGH: ports_high_q <= cfg.data[31:0];
				default: ;
			endcase
		end
	end

	// handshake: input register refills as soon as it drains
	assign advance   = valid_s1 && (!valid_s2 || res.ready);
	assign pkt.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.ready) begin
			valid_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			is_tcp_s1    <= pkt.is_tcp;
			dest_port_s1 <= pkt.dest_port;
			now_tick_s1  <= pkt.now_tick;
		end
	end

	// clamp length to the supported range
	always_comb begin
		if (seq_len_q < pknock_pkg::LEN_MIN) begin
			eff_len = pknock_pkg::LEN_MIN;
		end else if (seq_len_q > pknock_pkg::LEN_MAX) begin
			eff_len = pknock_pkg::LEN_MAX;
		end else begin
			eff_len = seq_len_q;
		end
	end

	assign hit_prot = is_tcp_s1 && (dest_port_s1 == prot_port_q);
	assign do_knock = is_tcp_s1 && !hit_prot;
	assign expired  = (now_tick_s1 - last_tick_q) > timeout_q;

	assign idx_base  = expired ? '0 : knock_idx_q;
	assign gate_base = expired ? 1'b0 : gate_open_q;
	assign last_base = expired ? '0 : last_tick_q;
	assign idx_inc   = idx_base + 4'd1;

	always_comb begin
		case (idx_base)
			4'd0:    slot_port = ports_low_q[15:0];
			4'd1:    slot_port = ports_low_q[31:16];
			4'd2:    slot_port = ports_low_q[47:32];
			4'd3:    slot_port = ports_low_q[63:48];
			4'd4:    slot_port = ports_mid_q[15:0];
			4'd5:    slot_port = ports_mid_q[31:16];
			4'd6:    slot_port = ports_mid_q[47:32];
			4'd7:    slot_port = ports_mid_q[63:48];
			4'd8:    slot_port = ports_high_q[15:0];
			4'd9:    slot_port = ports_high_q[31:16];
			default: slot_port = '0;
		endcase
	end

	assign match     = (idx_base < eff_len) && (dest_port_s1 == slot_port);
	assign idx_next  = match ? idx_inc : idx_base;
	assign gate_next = (match && (idx_inc >= eff_len)) ? 1'b1 : gate_base;
	assign last_next = match ? now_tick_s1 : last_base;

	assign accept_c       = hit_prot ? gate_open_q : 1'b1;
	assign gate_is_open_c = do_knock ? gate_next : gate_open_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_open_q <= 1'b0;
			knock_idx_q <= '0;
			last_tick_q <= '0;
		end else if (advance && do_knock) begin
			gate_open_q <= gate_next;
			knock_idx_q <= idx_next;
			last_tick_q <= last_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			accept_s2       <= accept_c;
			gate_is_open_s2 <= gate_is_open_c;
		end
	end

	assign res.valid        = valid_s2;
	assign res.accept       = accept_s2;
	assign res.gate_is_open = gate_is_open_s2;

	a_open_has_index: assert property (@(posedge clk) disable iff (!arst_n)
		gate_open_q |-> (knock_idx_q != '0))
		else $error("gate open with knock index zero");

	a_index_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		knock_idx_q <= pknock_pkg::LEN_MAX)
		else $error("knock index beyond sequence limit");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("result register not loaded after advance");

	a_drop_only_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !accept_c) |-> (hit_prot && !gate_open_q))
		else $error("packet dropped outside protected port with gate closed");

endmodule

`default_nettype wire
